@@ sv/assert_macros.svh @@
// Assertion helpers shared by the RTL. Each check samples on clk and is
// disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define CHK_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");
`define CHK_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`else
`define CHK_ALWAYS(lbl, expr)
`define CHK_IMPLY(lbl, ante, cons)
`endif
`endif

@@ sv/egp_pkg.sv @@
// ----------------------------------------------------------------------------
// egp_pkg
// Shared constants and types of the elliptic gradient pixel pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package egp_pkg;

  localparam int CORDIC_STEPS = 20;
  localparam int CHAN_W       = 8;
  localparam int NUM_CHAN     = 4;
  localparam logic [16:0] PROG_ONE = 17'h10000;

  // arctan(2^-i) in units of 2^-32 turn
  localparam logic [29:0] TURN_ATAN [0:CORDIC_STEPS-1] = '{
    30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
    30'd21354465,  30'd10679838,  30'd5340245,   30'd2670163,  30'd1335087,
    30'd667544,    30'd333772,    30'd166886,    30'd83443,    30'd41722,
    30'd20861,     30'd10430,     30'd5215,      30'd2608,     30'd1304
  };

  typedef enum logic [1:0] {
    CFG_RADIUS_X   = 2'd0,
    CFG_RADIUS_Y   = 2'd1,
    CFG_CONIC_MODE = 2'd2,
    CFG_STOP_COUNT = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    KIND_FIRST,
    KIND_LAST,
    KIND_BLEND
  } kind_t;

endpackage

@@ sv/elliptic_gradient_pixel.sv @@
// ----------------------------------------------------------------------------
// elliptic_gradient_pixel
// Shades one pixel of an elliptic gradient per clock from its offset to the
// centre; radial or conic progress, color stops blended in the squared domain.
// ----------------------------------------------------------------------------
// Usage:
//   Input words carry either a pixel offset (action 0) or a color stop write
//   (action 1). Each word takes one pipeline slot; a pixel gives one result
//   word, a stop write gives none but lands in the stop table in order.
//   Throughput is one word per clock: every divide, square root and CORDIC
//   step is a pipeline stage of its own (32 + 17 radial, 20 conic,
//   16 + 8 per color channel), so the 85-stage pipe sets the latency.
//   While an output word waits under out_stall the whole pipe holds and
//   in_stall is raised in the same cycle; nothing is lost or repeated.
//   Reset clears the valid bits and puts the config registers at defaults.
//   The stop table is undefined until written. Configuration writes must
//   come while the pipe is empty (not enforced); the derived radius products
//   settle after a write, before any new pixel reaches the inside test.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module elliptic_gradient_pixel
  import egp_pkg::*;
#(
  parameter int MAX_STOPS  = 8,
  parameter int COORD_BITS = 12
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_action,
  input  logic [COORD_BITS-1:0]        in_x_offset,
  input  logic [COORD_BITS-1:0]        in_y_offset,
  input  logic [2:0]                   in_stop_index,
  input  logic [16:0]                  in_stop_position,
  input  logic [31:0]                  in_stop_color,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [31:0]                  out_pixel_rgba,
  output logic                         out_inside_res,
  output logic [16:0]                  out_progress,
  input  logic                         cfg_we,
  input  logic [1:0]                   cfg_index,
  input  logic [10:0]                  cfg_data
);

  localparam int CB   = COORD_BITS;
  localparam int SQW  = 2 * CB;
  localparam int PW   = SQW + 22;
  localparam int NMW  = PW + 1;
  localparam int DNW  = 44;
  localparam int CMPW = (NMW > DNW) ? NMW : DNW;
  localparam int AW   = $clog2(MAX_STOPS);
  localparam int NSW  = $clog2(MAX_STOPS + 1);

  localparam int ST_ABS   = 1;
  localparam int ST_CMP   = 5;
  localparam int ST_DIV0  = 6;
  localparam int ST_RSQ0  = ST_DIV0 + 32;
  localparam int ST_SEL   = ST_RSQ0 + 17;
  localparam int ST_NORM  = ST_SEL - 1 - CORDIC_STEPS;
  localparam int ST_CRD0  = ST_NORM + 1;
  localparam int ST_RD    = ST_SEL + 1;
  localparam int ST_BSQ   = ST_RD + 1;
  localparam int ST_BMUL  = ST_BSQ + 1;
  localparam int ST_BSUM  = ST_BMUL + 1;
  localparam int ST_BDIV0 = ST_BSUM + 1;
  localparam int ST_BRT0  = ST_BDIV0 + 16;
  localparam int ST_OUT   = ST_BRT0 + 8;

  typedef struct packed {
    logic          act;
    logic [CB-1:0] x;
    logic [CB-1:0] y;
    logic [CB-1:0] ax;
    logic [CB-1:0] ay;
    logic [2:0]    sidx;
    logic [16:0]   spos;
    logic [31:0]   scol;
    logic          hit;
    logic [16:0]   prog;
  } front_t;

  typedef struct packed {
    logic        pix;
    logic        hit;
    logic        blend;
    logic [16:0] prog;
    logic [16:0] span;
    logic [31:0] color;
  } back_t;

  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // configuration
  logic [10:0] rx_r, ry_r;
  logic        mode_r;
  logic [3:0]  cnt_r;
  logic [10:0] rx_eff, ry_eff;
  logic [21:0] rx2_r, ry2_r;
  logic [DNW-1:0] dn_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_r   <= 11'd1;
      ry_r   <= 11'd1;
      mode_r <= 1'b0;
      cnt_r  <= 4'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RADIUS_X:   rx_r   <= cfg_data;
        CFG_RADIUS_Y:   ry_r   <= cfg_data;
        CFG_CONIC_MODE: mode_r <= cfg_data[0];
        CFG_STOP_COUNT: cnt_r  <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  assign rx_eff = (rx_r == '0) ? 11'd1 : rx_r;
  assign ry_eff = (ry_r == '0) ? 11'd1 : ry_r;

  always_ff @(posedge clk) begin
    rx2_r <= 22'(rx_eff) * 22'(rx_eff);
    ry2_r <= 22'(ry_eff) * 22'(ry_eff);
    dn_r  <= DNW'(rx2_r) * DNW'(ry2_r);
  end

  // valid bits and side data
  logic   vf_r   [0:ST_SEL];
  front_t mf_r   [0:ST_SEL];
  front_t mf_nxt [0:ST_SEL];
  logic   vb_r   [ST_RD:ST_OUT];
  back_t  mb_r   [ST_RD:ST_OUT];
  back_t  mb_nxt [ST_RD:ST_OUT];

  logic        inside_nxt;
  logic [16:0] prog_nxt;
  logic [31:0] rd0_r, rd1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s <= ST_SEL; s++) vf_r[s] <= 1'b0;
      for (int s = ST_RD; s <= ST_OUT; s++) vb_r[s] <= 1'b0;
    end else if (adv) begin
      vf_r[0] <= in_valid;
      for (int s = 1; s <= ST_SEL; s++) vf_r[s] <= vf_r[s-1];
      vb_r[ST_RD] <= vf_r[ST_SEL];
      for (int s = ST_RD + 1; s <= ST_OUT; s++) vb_r[s] <= vb_r[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int s = 0; s <= ST_SEL; s++) mf_r[s] <= mf_nxt[s];
      for (int s = ST_RD; s <= ST_OUT; s++) mb_r[s] <= mb_nxt[s];
    end
  end

  always_comb begin
    mf_nxt[0]      = '0;
    mf_nxt[0].act  = in_action;
    mf_nxt[0].x    = in_x_offset;
    mf_nxt[0].y    = in_y_offset;
    mf_nxt[0].sidx = in_stop_index;
    mf_nxt[0].spos = in_stop_position;
    mf_nxt[0].scol = in_stop_color;
    for (int s = 1; s <= ST_SEL; s++) mf_nxt[s] = mf_r[s-1];
    mf_nxt[ST_ABS].ax = mf_r[0].x[CB-1] ? CB'(~mf_r[0].x + 1'b1) : mf_r[0].x;
    mf_nxt[ST_ABS].ay = mf_r[0].y[CB-1] ? CB'(~mf_r[0].y + 1'b1) : mf_r[0].y;
    mf_nxt[ST_CMP].hit  = inside_nxt;
    mf_nxt[ST_SEL].prog = prog_nxt;
  end

  // inside test
  logic [SQW-1:0] ax2_r, ay2_r;
  logic [PW-1:0]  pa_r, pb_r;
  logic [NMW-1:0] nm_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      ax2_r <= SQW'(mf_r[ST_ABS].ax) * SQW'(mf_r[ST_ABS].ax);
      ay2_r <= SQW'(mf_r[ST_ABS].ay) * SQW'(mf_r[ST_ABS].ay);
      pa_r  <= PW'(ax2_r) * PW'(ry2_r);
      pb_r  <= PW'(ay2_r) * PW'(rx2_r);
      nm_r  <= NMW'(pa_r) + NMW'(pb_r);
    end
  end

  logic [DNW-1:0] dv_rem_r [ST_CMP:ST_RSQ0-1];
  logic [32:0]    dv_q_r   [ST_CMP:ST_RSQ0-1];
  logic           q0;

  assign inside_nxt = CMPW'(nm_r) <= CMPW'(dn_r);
  // inside, the integer part of nm/dn is one only on the rim
  assign q0 = CMPW'(nm_r) == CMPW'(dn_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_rem_r[ST_CMP] <= q0 ? '0 : DNW'(nm_r);
      dv_q_r[ST_CMP]   <= {32'b0, q0};
    end
  end

  // 32 fraction bits of nm/dn, one bit a stage
  for (genvar s = ST_DIV0; s < ST_RSQ0; s++) begin : g_rdiv
    logic [DNW:0] r2;
    logic         ge;
    assign r2 = {dv_rem_r[s-1], 1'b0};
    assign ge = r2 >= {1'b0, dn_r};
    always_ff @(posedge clk) begin
      if (adv) begin
        dv_rem_r[s] <= ge ? DNW'(r2 - {1'b0, dn_r}) : r2[DNW-1:0];
        dv_q_r[s]   <= {dv_q_r[s-1][31:0], ge};
      end
    end
  end

  // radial root, two radicand bits a stage
  logic [33:0] rs_v_r    [ST_RSQ0:ST_SEL-1];
  logic [19:0] rs_rem_r  [ST_RSQ0:ST_SEL-1];
  logic [16:0] rs_root_r [ST_RSQ0:ST_SEL-1];

  for (genvar s = ST_RSQ0; s < ST_SEL; s++) begin : g_rsqrt
    logic [33:0] v_in;
    logic [19:0] rem_in;
    logic [16:0] root_in;
    logic [21:0] work, test;
    logic        ge;
    if (s == ST_RSQ0) begin : g_first
      assign v_in    = {1'b0, dv_q_r[ST_RSQ0-1]};
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign v_in    = rs_v_r[s-1];
      assign rem_in  = rs_rem_r[s-1];
      assign root_in = rs_root_r[s-1];
    end
    assign work = {rem_in, v_in[33:32]};
    assign test = {3'b000, root_in, 2'b01};
    assign ge   = work >= test;
    always_ff @(posedge clk) begin
      if (adv) begin
        rs_v_r[s]    <= {v_in[31:0], 2'b00};
        rs_rem_r[s]  <= ge ? 20'(work - test) : work[19:0];
        rs_root_r[s] <= {root_in[15:0], ge};
      end
    end
  end

  // conic angle: normalize, then vectoring CORDIC
  logic signed [33:0] cx_r [ST_NORM:ST_SEL-1];
  logic signed [33:0] cy_r [ST_NORM:ST_SEL-1];
  logic signed [32:0] z_r  [ST_NORM:ST_SEL-1];
  logic [CB-1:0]      nrm_m;
  logic [4:0]         nrm_msb, nrm_sh;

  always_comb begin
    nrm_m   = mf_r[ST_NORM-1].ax | mf_r[ST_NORM-1].ay;
    nrm_msb = '0;
    for (int b = 0; b < CB; b++) begin
      if (nrm_m[b]) nrm_msb = 5'(b);
    end
    nrm_sh = 5'd29 - nrm_msb;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cx_r[ST_NORM] <= $signed(34'(mf_r[ST_NORM-1].ax) << nrm_sh);
      cy_r[ST_NORM] <= $signed(34'(mf_r[ST_NORM-1].ay) << nrm_sh);
      z_r[ST_NORM]  <= '0;
    end
  end

  for (genvar s = ST_CRD0; s < ST_SEL; s++) begin : g_cordic
    localparam int I = s - ST_CRD0;
    logic signed [33:0] dx, dy;
    logic signed [32:0] da;
    assign dx = cy_r[s-1] >>> I;
    assign dy = cx_r[s-1] >>> I;
    assign da = $signed({3'b000, TURN_ATAN[I]});
    always_ff @(posedge clk) begin
      if (adv) begin
        if (!cy_r[s-1][33]) begin
          cx_r[s] <= cx_r[s-1] + dx;
          cy_r[s] <= cy_r[s-1] - dy;
          z_r[s]  <= z_r[s-1] + da;
        end else begin
          cx_r[s] <= cx_r[s-1] - dx;
          cy_r[s] <= cy_r[s-1] + dy;
          z_r[s]  <= z_r[s-1] - da;
        end
      end
    end
  end

  // progress select
  logic [32:0] cz;
  logic [30:0] ang_t;
  logic [32:0] p32;
  front_t      mp;

  always_comb begin
    mp = mf_r[ST_SEL-1];
    cz = z_r[ST_SEL-1];
    if (cz[32]) ang_t = '0;
    else if (cz[31:0] > 32'h4000_0000) ang_t = 31'h4000_0000;
    else ang_t = cz[30:0];
    if (mp.ay == '0) ang_t = '0;
    else if (mp.ax == '0) ang_t = 31'h4000_0000;
    if (!mp.x[CB-1] && !mp.y[CB-1]) p32 = 33'h0_8000_0000 + 33'(ang_t);
    else if (mp.x[CB-1] && !mp.y[CB-1]) p32 = 33'h1_0000_0000 - 33'(ang_t);
    else if (mp.x[CB-1]) p32 = 33'(ang_t);
    else p32 = 33'h0_8000_0000 - 33'(ang_t);
    if (!mp.hit) prog_nxt = '0;
    else if (mode_r) prog_nxt = p32[32:16];
    else prog_nxt = rs_root_r[ST_SEL-1];
  end

  // stop search and table read
  logic [16:0]    pos_r    [0:MAX_STOPS-1];
  logic [48:0]    stop_mem [0:MAX_STOPS-1];
  logic [48:0]    mrd0_r, mrd1_r;
  logic [NSW-1:0] n_c, kf;
  kind_t          kind;
  logic [AW-1:0]  a0, a1, widx;
  logic           wr;
  front_t         ms;

  always_comb begin
    ms = mf_r[ST_SEL];
    if (cnt_r == '0) n_c = NSW'(1);
    else if (int'(cnt_r) > MAX_STOPS) n_c = NSW'(MAX_STOPS);
    else n_c = NSW'(cnt_r);
    kf = n_c;
    for (int k = MAX_STOPS - 1; k >= 0; k--) begin
      if (k < int'(n_c) && pos_r[k] >= ms.prog) kf = NSW'(k);
    end
    if (kf == '0) kind = KIND_FIRST;
    else if (kf == n_c) kind = KIND_LAST;
    else kind = KIND_BLEND;
    case (kind)
      KIND_FIRST: a0 = '0;
      KIND_LAST:  a0 = AW'(n_c - 1'b1);
      default:    a0 = AW'(kf - 1'b1);
    endcase
    a1   = (kind == KIND_BLEND) ? AW'(kf) : a0;
    wr   = vf_r[ST_SEL] && ms.act && (int'(ms.sidx) < MAX_STOPS);
    widx = AW'(ms.sidx);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mrd0_r <= stop_mem[a0];
      mrd1_r <= stop_mem[a1];
      if (wr) stop_mem[widx] <= {ms.spos, ms.scol};
    end
  end

  always_ff @(posedge clk) begin
    if (adv && wr) pos_r[widx] <= ms.spos;
  end

  assign rd0_r = mrd0_r[31:0];
  assign rd1_r = mrd1_r[31:0];

  always_comb begin
    mb_nxt[ST_RD]       = '0;
    mb_nxt[ST_RD].pix   = !ms.act;
    mb_nxt[ST_RD].hit   = ms.hit;
    mb_nxt[ST_RD].blend = (kind == KIND_BLEND);
    mb_nxt[ST_RD].prog  = ms.prog;
    for (int s = ST_RD + 1; s <= ST_OUT; s++) mb_nxt[s] = mb_r[s-1];
    mb_nxt[ST_BSQ].color = rd0_r;
    mb_nxt[ST_BSQ].span  = mrd1_r[48:32] - mrd0_r[48:32];
  end

  // channel blend: squares, weights, weighted sum, divide by span, square root
  logic [15:0] a2_r [0:NUM_CHAN-1];
  logic [15:0] b2_r [0:NUM_CHAN-1];
  logic [31:0] m0_r [0:NUM_CHAN-1];
  logic [31:0] m1_r [0:NUM_CHAN-1];
  logic [16:0] w0_r, w1_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      w0_r <= mrd1_r[48:32] - mb_r[ST_RD].prog;
      w1_r <= mb_r[ST_RD].prog - mrd0_r[48:32];
    end
  end

  logic [16:0] bd_rem_r [ST_BSUM:ST_BRT0-1][0:NUM_CHAN-1];
  logic [15:0] bd_low_r [ST_BSUM:ST_BRT0-1][0:NUM_CHAN-1];
  logic [15:0] bd_q_r   [ST_BSUM:ST_BRT0-1][0:NUM_CHAN-1];
  logic [15:0] br_v_r    [ST_BRT0:ST_OUT-1][0:NUM_CHAN-1];
  logic [9:0]  br_rem_r  [ST_BRT0:ST_OUT-1][0:NUM_CHAN-1];
  logic [7:0]  br_root_r [ST_BRT0:ST_OUT-1][0:NUM_CHAN-1];

  for (genvar l = 0; l < NUM_CHAN; l++) begin : g_lane
    logic [CHAN_W-1:0] ca, cb;
    logic [31:0]       sum;
    assign ca  = rd0_r[CHAN_W*l +: CHAN_W];
    assign cb  = rd1_r[CHAN_W*l +: CHAN_W];
    assign sum = m0_r[l] + m1_r[l];
    always_ff @(posedge clk) begin
      if (adv) begin
        a2_r[l] <= 16'(ca) * 16'(ca);
        b2_r[l] <= 16'(cb) * 16'(cb);
        m0_r[l] <= 32'(33'(a2_r[l]) * 33'(w0_r));
        m1_r[l] <= 32'(33'(b2_r[l]) * 33'(w1_r));
        // quotient stays below 2^16, so the top half is already below span
        bd_rem_r[ST_BSUM][l] <= {1'b0, sum[31:16]};
        bd_low_r[ST_BSUM][l] <= sum[15:0];
        bd_q_r[ST_BSUM][l]   <= '0;
      end
    end

    for (genvar s = ST_BDIV0; s < ST_BRT0; s++) begin : g_bdiv
      logic [17:0] r2, sp;
      logic        ge;
      assign r2 = {bd_rem_r[s-1][l], bd_low_r[s-1][l][15]};
      assign sp = {1'b0, mb_r[s-1].span};
      assign ge = r2 >= sp;
      always_ff @(posedge clk) begin
        if (adv) begin
          bd_rem_r[s][l] <= ge ? 17'(r2 - sp) : r2[16:0];
          bd_low_r[s][l] <= {bd_low_r[s-1][l][14:0], 1'b0};
          bd_q_r[s][l]   <= {bd_q_r[s-1][l][14:0], ge};
        end
      end
    end

    for (genvar s = ST_BRT0; s < ST_OUT; s++) begin : g_bsqrt
      logic [15:0] v_in;
      logic [9:0]  rem_in;
      logic [7:0]  root_in;
      logic [11:0] work, test;
      logic        ge;
      if (s == ST_BRT0) begin : g_first
        assign v_in    = bd_q_r[ST_BRT0-1][l];
        assign rem_in  = '0;
        assign root_in = '0;
      end else begin : g_next
        assign v_in    = br_v_r[s-1][l];
        assign rem_in  = br_rem_r[s-1][l];
        assign root_in = br_root_r[s-1][l];
      end
      assign work = {rem_in, v_in[15:14]};
      assign test = {2'b00, root_in, 2'b01};
      assign ge   = work >= test;
      always_ff @(posedge clk) begin
        if (adv) begin
          br_v_r[s][l]    <= {v_in[13:0], 2'b00};
          br_rem_r[s][l]  <= ge ? 10'(work - test) : work[9:0];
          br_root_r[s][l] <= {root_in[6:0], ge};
        end
      end
    end
  end

  // output word
  logic [31:0] rgba_r;
  logic [31:0] blend_rgba;

  always_comb begin
    for (int l = 0; l < NUM_CHAN; l++) begin
      blend_rgba[CHAN_W*l +: CHAN_W] = br_root_r[ST_OUT-1][l];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (!mb_r[ST_OUT-1].hit) rgba_r <= '0;
      else if (mb_r[ST_OUT-1].blend) rgba_r <= blend_rgba;
      else rgba_r <= mb_r[ST_OUT-1].color;
    end
  end

  assign out_valid      = vb_r[ST_OUT] && mb_r[ST_OUT].pix;
  assign out_pixel_rgba = rgba_r;
  assign out_inside_res = mb_r[ST_OUT].hit;
  assign out_progress   = mb_r[ST_OUT].prog;

  `CHK_ALWAYS(a_stall_src, in_stall == (out_valid && out_stall))
  `CHK_IMPLY(a_outside_zero, out_valid && !out_inside_res, out_pixel_rgba == '0 && out_progress == '0)
  `CHK_IMPLY(a_prog_range, out_valid, out_progress <= PROG_ONE)

endmodule

@@ dv/elliptic_gradient_pixel_tb.sv @@
// ----------------------------------------------------------------------------
// elliptic_gradient_pixel_tb
// Drives pixel and stop-write words through the gradient shader with random
// bursts, gaps and output stalls, predicts every pixel word in place and
// checks results in order across several radius, mode and stop settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module elliptic_gradient_pixel_tb;
  import egp_pkg::*;

  localparam logic ACT_SHADE = 1'b0;
  localparam logic ACT_STOP  = 1'b1;
  localparam int   N_STOPS   = 8;
  localparam int   PIPE_WAIT = 100;

  typedef struct packed {
    logic [31:0] rgba;
    logic        hit;
    logic [16:0] prog;
  } pix_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid, in_stall, in_action;
  logic [11:0] in_x_offset, in_y_offset;
  logic [2:0]  in_stop_index;
  logic [16:0] in_stop_position;
  logic [31:0] in_stop_color;
  logic        out_valid, out_stall, out_inside_res;
  logic [31:0] out_pixel_rgba;
  logic [16:0] out_progress;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [10:0] cfg_data;

  // shader state as the predictor sees it
  logic [10:0] g_rx, g_ry;
  logic        g_conic;
  logic [3:0]  g_count;
  logic [16:0] g_pos [N_STOPS];
  logic [31:0] g_col [N_STOPS];

  pix_t pixel_q[$];
  int   errors = 0, n_pix = 0, n_inside = 0, n_stops = 0, n_checked = 0;
  int   stall_pct = 0, burst_left = 0;

  elliptic_gradient_pixel i_dut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (stall_pct == 0) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < stall_pct);
  end

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] root, b;
    root = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= root + b) begin
        v -= root + b;
        root = (root >> 1) + b;
      end else begin
        root >>= 1;
      end
      b >>= 2;
    end
    return root;
  endfunction

  // first-quadrant angle in 2^-32 turn, vectoring CORDIC
  function automatic logic [63:0] quad_angle(logic [63:0] ax, logic [63:0] ay);
    longint cx, cy, z, dx, dy;
    z = 0;
    if (ay == 0) return 0;
    if (ax == 0) return 64'd1 << 30;
    while (((ax | ay) >> 29) == 0) begin
      ax <<= 1;
      ay <<= 1;
    end
    cx = ax;
    cy = ay;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (cy >= 0) begin
        cx += dx; cy -= dy; z += longint'(TURN_ATAN[i]);
      end else begin
        cx -= dx; cy += dy; z -= longint'(TURN_ATAN[i]);
      end
    end
    if (z < 0) z = 0;
    if (z > (longint'(1) << 30)) z = longint'(1) << 30;
    return z;
  endfunction

  function automatic logic [31:0] blend_color(logic [31:0] c0, logic [31:0] c1,
                                              logic [63:0] p0, logic [63:0] p1,
                                              logic [63:0] p);
    logic [31:0] res;
    logic [63:0] a, b, v;
    res = 0;
    for (int sh = 0; sh < 32; sh += 8) begin
      a = (c0 >> sh) & 8'hFF;
      b = (c1 >> sh) & 8'hFF;
      v = (a * a * (p1 - p) + b * b * (p - p0)) / (p1 - p0);
      res |= (int_sqrt(v) & 8'hFF) << sh;
    end
    return res;
  endfunction

  function automatic pix_t shade_pixel(logic signed [11:0] x, logic signed [11:0] y);
    pix_t r;
    longint xs, ys;
    logic [63:0] ax, ay, rx, ry, nm, dn, q, rem, p, t;
    int n, k;
    xs = x;
    ys = y;
    ax = xs < 0 ? -xs : xs;
    ay = ys < 0 ? -ys : ys;
    rx = g_rx == 0 ? 1 : g_rx;
    ry = g_ry == 0 ? 1 : g_ry;
    nm = ax * ax * ry * ry + ay * ay * rx * rx;
    dn = rx * rx * ry * ry;
    r = '0;
    if (nm > dn) return r;
    if (!g_conic) begin
      q = nm / dn;
      rem = nm - q * dn;
      for (int i = 0; i < 32; i++) begin
        rem <<= 1;
        q <<= 1;
        if (rem >= dn) begin
          rem -= dn;
          q |= 1;
        end
      end
      p = int_sqrt(q);
    end else begin
      t = quad_angle(ax, ay);
      if (xs >= 0 && ys >= 0) p = (64'd1 << 31) + t;
      else if (xs < 0 && ys >= 0) p = (64'd1 << 32) - t;
      else if (xs < 0) p = t;
      else p = (64'd1 << 31) - t;
      p >>= 16;
    end
    n = g_count == 0 ? 1 : (g_count > N_STOPS ? N_STOPS : g_count);
    for (k = 0; k < n; k++)
      if (g_pos[k] >= p) break;
    if (k == 0) r.rgba = g_col[0];
    else if (k == n) r.rgba = g_col[n-1];
    else r.rgba = blend_color(g_col[k-1], g_col[k], g_pos[k-1], g_pos[k], p);
    r.hit = 1'b1;
    r.prog = p[16:0];
    return r;
  endfunction

  // one word out; returns once it is taken, then maybe opens a gap
  task automatic send_word(logic act, logic [11:0] x, logic [11:0] y,
                           logic [2:0] idx, logic [16:0] pos, logic [31:0] col);
    pix_t e;
    in_valid <= 1'b1;
    in_action <= act;
    in_x_offset <= x;
    in_y_offset <= y;
    in_stop_index <= idx;
    in_stop_position <= pos;
    in_stop_color <= col;
    do @(posedge clk); while (in_stall);
    if (act == ACT_STOP) begin
      g_pos[idx] = pos;
      g_col[idx] = col;
      n_stops++;
    end else begin
      e = shade_pixel(x, y);
      pixel_q.insert(pixel_q.size(), e);
      n_pix++;
      if (e.hit) n_inside++;
    end
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(20);
      if ($urandom_range(3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(6, 1)) @(posedge clk);
      end
    end
  endtask

  task automatic drain();
    if (in_valid) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (PIPE_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [10:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_RADIUS_X:   g_rx = val;
      CFG_RADIUS_Y:   g_ry = val;
      CFG_CONIC_MODE: g_conic = val[0];
      default:        g_count = val[3:0];
    endcase
    repeat (3) @(posedge clk);
  endtask

  task automatic setup(logic [10:0] rx, logic [10:0] ry, logic conic, logic [3:0] cnt);
    drain();
    write_reg(CFG_RADIUS_X, rx);
    write_reg(CFG_RADIUS_Y, ry);
    write_reg(CFG_CONIC_MODE, 11'(conic));
    write_reg(CFG_STOP_COUNT, 11'(cnt));
  endtask

  task automatic shade(int x, int y);
    send_word(ACT_SHADE, x[11:0], y[11:0], 3'($urandom), 17'($urandom), $urandom);
  endtask

  task automatic put_stop(int idx, logic [16:0] pos, logic [31:0] col);
    send_word(ACT_STOP, 12'($urandom), 12'($urandom), idx[2:0], pos, col);
  endtask

  task automatic test_directed();
    setup(11'd100, 11'd60, 1'b0, 4'd4);
    put_stop(0, 17'd0, 32'hFF000000);
    put_stop(1, 17'd20000, 32'h00FF00FF);
    put_stop(2, 17'd40000, 32'h0000FFFF);
    put_stop(3, 17'd65536, 32'hFFFFFFFF);
    for (int i = 4; i < N_STOPS; i++) put_stop(i, 17'd65536, 32'h80808080);
    shade(0, 0);
    shade(-100, 0);
    shade(99, 0);
    shade(100, 0);
    shade(0, -60);
    shade(0, 59);
    shade(70, 40);
    shade(-2048, -2048);
    shade(2047, 2047);
    setup(11'd100, 11'd60, 1'b1, 4'd4);
    shade(5, 0);
    shade(0, 5);
    shade(-5, 0);
    shade(0, -5);
    shade(-3, -3);
    shade(3, -3);
    shade(-4, 2);
  endtask

  task automatic test_reg_extremes();
    // zero radius acts as one; stop count zero acts as one, large saturates
    setup(11'd0, 11'd0, 1'b0, 4'd0);
    shade(0, 0);
    shade(1, 0);
    shade(-1, 0);
    shade(0, -1);
    setup(11'd2047, 11'd2047, 1'b0, 4'd15);
    shade(-2047, 0);
    shade(0, 2047);
    shade(-2048, 0);
    shade(1447, -1447);
    shade(1000, 1000);
  endtask

  task automatic test_unordered_stops();
    setup(11'd40, 11'd40, 1'b1, 4'd8);
    for (int i = 0; i < N_STOPS; i++)
      put_stop(i, 17'(65536 - i * 9000), $urandom);
    for (int i = 0; i < 20; i++)
      shade($urandom_range(80) - 40, $urandom_range(80) - 40);
  endtask

  task automatic test_random_phase(logic [10:0] rx, logic [10:0] ry, logic conic,
                                   logic [3:0] cnt, int items);
    int x, y, idx;
    setup(rx, ry, conic, cnt);
    for (int i = 0; i < items; i++) begin
      if ($urandom_range(99) < 15) begin
        idx = $urandom_range(N_STOPS - 1);
        if ($urandom_range(9) == 0) put_stop(idx, 17'($urandom_range(65536)), $urandom);
        else put_stop(idx, 17'(idx * 8192 + $urandom_range(8192)), $urandom);
      end else if ($urandom_range(9) == 0) begin
        shade($urandom, $urandom);
      end else begin
        x = $urandom_range(2 * (rx + 2)) - (rx + 2);
        y = $urandom_range(2 * (ry + 2)) - (ry + 2);
        shade(x, y);
      end
    end
  endtask

  task automatic test_random();
    logic [10:0] rx, ry;
    for (int ph = 0; ph < 8; ph++) begin
      stall_pct = (ph % 3 == 0) ? 0 : (ph % 3 == 1 ? 30 : 70);
      if (ph == 6) begin
        rx = 11'd2047; ry = 11'd1;
      end else if (ph == 7) begin
        rx = 11'd1; ry = 11'd2047;
      end else if (ph < 3) begin
        rx = 11'($urandom_range(40, 1)); ry = 11'($urandom_range(40, 1));
      end else begin
        rx = 11'($urandom_range(2047, 1)); ry = 11'($urandom_range(2047, 1));
      end
      test_random_phase(rx, ry, ph[0], 4'($urandom_range(8, 1)), 70);
    end
  endtask

  // result checker
  always @(posedge clk) begin
    pix_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pixel_q.size() == 0) begin
        $display("%0t: unexpected pixel word rgba=%h inside=%0d prog=%0d", $time,
                 out_pixel_rgba, out_inside_res, out_progress);
        errors++;
      end else begin
        e = pixel_q.pop_front();
        n_checked++;
        if (e.rgba !== out_pixel_rgba) begin
          $display("%0t: pixel_rgba expected %h actual %h", $time, e.rgba, out_pixel_rgba);
          errors++;
        end
        if (e.hit !== out_inside_res) begin
          $display("%0t: inside_res expected %0d actual %0d", $time, e.hit,
                   out_inside_res);
          errors++;
        end
        if (e.prog !== out_progress) begin
          $display("%0t: progress expected %0d actual %0d", $time, e.prog, out_progress);
          errors++;
        end
      end
    end
  end

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_action <= ACT_SHADE;
    in_x_offset <= '0;
    in_y_offset <= '0;
    in_stop_index <= '0;
    in_stop_position <= '0;
    in_stop_color <= '0;
    out_stall <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_RADIUS_X;
    cfg_data <= '0;
    g_rx = 11'd1;
    g_ry = 11'd1;
    g_conic = 1'b0;
    g_count = 4'd1;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    stall_pct = 40;
    test_reg_extremes();
    test_unordered_stops();
    test_random();
    drain();
    $display("Checked %0d pixel words (%0d inside) and %0d stop writes over", n_checked,
             n_inside, n_stops);
    $display("radial and conic modes, extreme radii and stop counts, with stalls and gaps.");
    if (errors == 0 && pixel_q.size() == 0) $display("elliptic_gradient_pixel test passed");
    else $display("elliptic_gradient_pixel test failed");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("%0t: timeout", $time);
    $display("elliptic_gradient_pixel test failed");
    $finish;
  end

endmodule
